[hdl/campose_pkg.sv]
package campose_pkg;

    // Position format and iteration counts
    localparam int POS_FRAC_BITS = 16;
    localparam int CORDIC_ITERS  = 16;
    localparam int DELTA_SHIFT   = 38 - POS_FRAC_BITS;
    localparam int ITER_W        = 5;
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 15;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [18:0] ONE_Q14     = 19'sd16384;

    localparam logic signed [31:0] EYE_RST_X = 32'(64'sd10 <<< POS_FRAC_BITS);
    localparam logic signed [31:0] EYE_RST_Y = 32'(64'sd8 <<< POS_FRAC_BITS);
    localparam logic signed [31:0] EYE_RST_Z = 32'(64'sd10 <<< POS_FRAC_BITS);

    // Command codes carried in tuser
    localparam logic [1:0] CMD_MOVE  = 2'd0;
    localparam logic [1:0] CMD_PITCH = 2'd1;
    localparam logic [1:0] CMD_YAW   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_UP_X  = 2'd0;
    localparam logic [1:0] CFG_UP_Y  = 2'd1;
    localparam logic [1:0] CFG_UP_Z  = 2'd2;
    localparam logic [1:0] CFG_SPEED = 2'd3;

    // Move flag positions
    localparam logic [1:0] SHF_LEFT  = 2'd0;
    localparam logic [1:0] SHF_RIGHT = 2'd1;
    localparam logic [1:0] SHF_FWD   = 2'd2;
    localparam logic [1:0] SHF_BACK  = 2'd3;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_VIEW,
        OP_NSCALE,
        OP_SQ,
        OP_SQEND,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_DIV_WR,
        OP_CROSS1,
        OP_CROSS2,
        OP_SCALE,
        OP_DELTA,
        OP_SHIFT,
        OP_AXIS,
        OP_CORDIC_INIT,
        OP_CORDIC,
        OP_CS,
        OP_MA,
        OP_MB,
        OP_MC,
        OP_MD,
        OP_RM,
        OP_RE,
        OP_RW,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_VIEW,
        ST_NSCALE,
        ST_SQ,
        ST_SQEND,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_WR,
        ST_CROSS1,
        ST_CROSS2,
        ST_SCALE,
        ST_DELTA,
        ST_SHIFT,
        ST_AXIS,
        ST_CORDIC_INIT,
        ST_CORDIC,
        ST_CS,
        ST_MA,
        ST_MB,
        ST_MC,
        ST_MD,
        ST_RVIEW,
        ST_RM,
        ST_RE,
        ST_RW,
        ST_OUT
    } ctl_state_t;

    // Command from controller to datapath
    typedef struct packed {
        dp_op_t     op;
        logic [1:0] row;
        logic [1:0] col;
        logic       sel;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic       iter_last;
        logic [1:0] cmd;
        logic [3:0] flags;
        logic       out_free;
    } dp_stat_t;

    // Next index modulo three
    function automatic logic [1:0] nxt3(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // Arctangent of 2^-i in signed Q4.30
    function automatic logic signed [34:0] atan_q30(input logic [ITER_W-1:0] i);
        logic signed [34:0] v;
        unique case (i)
            5'd0:  v = 35'sh03243F6A8;
            5'd1:  v = 35'sh01DAC6705;
            5'd2:  v = 35'sh00FADBAFC;
            5'd3:  v = 35'sh007F56EA6;
            5'd4:  v = 35'sh003FEAB76;
            5'd5:  v = 35'sh001FFD55B;
            5'd6:  v = 35'sh000FFFAAA;
            5'd7:  v = 35'sh0007FFF55;
            5'd8:  v = 35'sh0003FFFEA;
            5'd9:  v = 35'sh0001FFFFD;
            5'd10: v = 35'sh0000FFFFF;
            5'd11: v = 35'sh00007FFFF;
            5'd12: v = 35'sh00003FFFF;
            5'd13: v = 35'sh00001FFFF;
            5'd14: v = 35'sh00000FFFF;
            5'd15: v = 35'sh000007FFF;
            5'd16: v = 35'sh000003FFF;
            5'd17: v = 35'sh000001FFF;
            5'd18: v = 35'sh000000FFF;
            5'd19: v = 35'sh0000007FF;
            5'd20: v = 35'sh0000003FF;
            5'd21: v = 35'sh0000001FF;
            5'd22: v = 35'sh0000000FF;
            5'd23: v = 35'sh00000007F;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/camera_pose_update_core.sv]
// Free-fly camera pose engine. One command word in, one pose word out. The
// pose is held inside and starts at eye (10, 8, 10), center at the origin.
// Words are processed one at a time by a sequencer over a shared multiplier,
// a bit-serial square root, a shift-subtract divider run once per component
// and a CORDIC unit (16 iterations). A move tick and a pitch each run two
// vector normalizations; a pitch and a yaw each run the CORDIC and the
// nine-entry matrix build; an unused command code goes straight to output.
// A finished pose waits in the output register while the next command is
// accepted. The user must write configuration only while the block is
// idle; the block itself does not enforce it.
module camera_pose_update_core
    import campose_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // go_left, go_right, go_forward, go_back, delta_time[15:0], turn_angle[15:0]
    input  logic [39:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // eye_x, eye_y, eye_z, look_x, look_y, look_z (32 bits each), saturated
    output logic [199:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    campose_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    campose_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[hdl/campose_ctrl.sv]
module campose_ctrl
    import campose_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       sel_reg, sel_next;

    // State and index registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            sel_reg   <= sel_next;
        end
    end

    // Sequence the datapath
    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        sel_next   = sel_reg;
        cmd.op     = OP_NOP;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.sel    = sel_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                sel_next = 1'b0;
                col_next = 2'd0;
                row_next = 2'd0;
                if (stat.cmd == CMD_MOVE || stat.cmd == CMD_PITCH) begin
                    state_next = ST_VIEW;
                end else if (stat.cmd == CMD_YAW) begin
                    state_next = ST_AXIS;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_VIEW: begin
                cmd.op     = OP_VIEW;
                state_next = ST_NSCALE;
            end
            ST_NSCALE: begin
                cmd.op     = OP_NSCALE;
                col_next   = 2'd0;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op = OP_SQ;
                if (col_reg == 2'd2) begin
                    state_next = ST_SQEND;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_SQEND: begin
                cmd.op     = OP_SQEND;
                state_next = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                cmd.op     = OP_SQRT_INIT;
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op = OP_SQRT;
                if (stat.iter_last) begin
                    col_next   = 2'd0;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                cmd.op     = OP_DIV_INIT;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (stat.iter_last) begin
                    state_next = ST_DIV_WR;
                end
            end
            ST_DIV_WR: begin
                cmd.op = OP_DIV_WR;
                if (col_reg == 2'd2) begin
                    col_next = 2'd0;
                    if (!sel_reg) begin
                        state_next = ST_CROSS1;
                    end else if (stat.cmd == CMD_MOVE) begin
                        sel_next   = 1'b0;
                        state_next = ST_SCALE;
                    end else begin
                        state_next = ST_AXIS;
                    end
                end else begin
                    col_next   = col_reg + 2'd1;
                    state_next = ST_DIV_INIT;
                end
            end
            ST_CROSS1: begin
                cmd.op     = OP_CROSS1;
                state_next = ST_CROSS2;
            end
            ST_CROSS2: begin
                cmd.op = OP_CROSS2;
                if (col_reg == 2'd2) begin
                    sel_next   = 1'b1;
                    state_next = ST_NSCALE;
                end else begin
                    col_next   = col_reg + 2'd1;
                    state_next = ST_CROSS1;
                end
            end
            ST_SCALE: begin
                cmd.op     = OP_SCALE;
                col_next   = 2'd0;
                state_next = ST_DELTA;
            end
            ST_DELTA: begin
                cmd.op = OP_DELTA;
                if (col_reg == 2'd2) begin
                    col_next = 2'd0;
                    if (sel_reg) begin
                        state_next = ST_SHIFT;
                    end else begin
                        sel_next = 1'b1;
                    end
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_SHIFT: begin
                // Apply each set flag in order left, right, forward, back
                if (stat.flags[col_reg]) begin
                    cmd.op = OP_SHIFT;
                end
                if (col_reg == SHF_BACK) begin
                    state_next = ST_OUT;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_AXIS: begin
                cmd.op     = OP_AXIS;
                state_next = ST_CORDIC_INIT;
            end
            ST_CORDIC_INIT: begin
                cmd.op     = OP_CORDIC_INIT;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.op = OP_CORDIC;
                if (stat.iter_last) begin
                    state_next = ST_CS;
                end
            end
            ST_CS: begin
                cmd.op     = OP_CS;
                row_next   = 2'd0;
                col_next   = 2'd0;
                state_next = ST_MA;
            end
            ST_MA: begin
                cmd.op     = OP_MA;
                state_next = ST_MB;
            end
            ST_MB: begin
                cmd.op     = OP_MB;
                state_next = ST_MC;
            end
            ST_MC: begin
                cmd.op     = OP_MC;
                state_next = ST_MD;
            end
            ST_MD: begin
                // Walk the nine matrix entries row by row
                cmd.op     = OP_MD;
                state_next = ST_MA;
                if (col_reg == 2'd2) begin
                    col_next = 2'd0;
                    if (row_reg == 2'd2) begin
                        row_next   = 2'd0;
                        state_next = ST_RVIEW;
                    end else begin
                        row_next = row_reg + 2'd1;
                    end
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_RVIEW: begin
                cmd.op     = OP_VIEW;
                state_next = ST_RM;
            end
            ST_RM: begin
                cmd.op = OP_RM;
                if (col_reg == 2'd2) begin
                    state_next = ST_RE;
                end else begin
                    col_next = col_reg + 2'd1;
                end
            end
            ST_RE: begin
                cmd.op     = OP_RE;
                state_next = ST_RW;
            end
            ST_RW: begin
                cmd.op   = OP_RW;
                col_next = 2'd0;
                if (row_reg == 2'd2) begin
                    state_next = ST_OUT;
                end else begin
                    row_next   = row_reg + 2'd1;
                    state_next = ST_RM;
                end
            end
            ST_OUT: begin
                // Hold until the output register can take the word
                if (stat.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/campose_dp.sv]
module campose_dp
    import campose_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    input  logic [39:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_wdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [199:0]  m_tdata
);

    // Configuration and pose
    logic signed [15:0] up_reg [3];
    logic [15:0]        speed_reg;
    logic signed [31:0] eye_reg [3];
    logic signed [31:0] look_reg [3];
    logic               sat_reg;
    logic               out_valid_reg;
    logic [199:0]       out_data_reg;
    logic [ITER_W-1:0]  iter_reg;

    // Latched item
    logic [3:0]         flags_reg;
    logic [1:0]         cmdin_reg;
    logic [15:0]        dt_reg;
    logic signed [15:0] ang_reg;

    // Working registers
    logic signed [32:0] vec_reg [3];
    logic [29:0]        amag_reg [3];
    logic [2:0]         sgn_reg;
    logic [61:0]        sum_reg;
    logic signed [63:0] prod_reg;
    logic [61:0]        sq_n_reg;
    logic [62:0]        sq_res_reg;
    logic [62:0]        sq_bit_reg;
    logic [43:0]        rem_reg;
    logic [44:0]        dsr_reg;
    logic [14:0]        q_reg;
    logic signed [15:0] fwd_reg [3];
    logic signed [15:0] rgt_reg [3];
    logic signed [15:0] axis_reg [3];
    logic [31:0]        scale_reg;
    logic signed [31:0] df_reg [3];
    logic signed [31:0] dr_reg [3];
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [34:0] cz_reg;
    logic               flip_reg;
    logic signed [17:0] cos_reg, sin_reg;
    logic signed [18:0] omc_reg;
    logic signed [51:0] m_reg;
    logic signed [27:0] mr_reg [3][3];
    logic signed [63:0] acc_reg;

    // Shared multiplier
    logic signed [32:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [63:0] mul_p;

    logic [1:0]         ca, cb, kx;
    logic [32:0]        mag [3];
    logic [32:0]        mmax;
    logic [1:0]         nsh;
    logic [63:0]        sq_try;
    logic               sq_take;
    logic [30:0]        len;
    logic signed [15:0] qs, unit_val;
    logic signed [63:0] dsum, dshift;
    logic signed [33:0] cxs, cys, xf, yf, cr, sr;
    logic signed [34:0] z0, at;
    logic signed [51:0] mterm;
    logic signed [51:0] mrnd;
    logic signed [65:0] rw_sum;
    logic signed [45:0] rw_val;
    logic [32:0]        rw_clamp;
    logic signed [31:0] sh_d [3];
    logic [32:0]        eye_clamp [3];
    logic [32:0]        look_clamp [3];
    logic [2:0]         sh_sat;

    // Clamp to the signed 32-bit range, flag in the top bit
    function automatic logic [32:0] clamp46(input logic signed [45:0] v);
        logic [32:0] r;
        if (v > 46'sd2147483647) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -46'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    assign ca = nxt3(cmd.col);
    assign cb = nxt3(ca);
    assign kx = 2'd3 - cmd.row - cmd.col;
    assign len = sq_res_reg[30:0];

    // Select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQ: begin
                mul_a = {3'b000, amag_reg[cmd.col]};
                mul_b = {1'b0, amag_reg[cmd.col]};
            end
            OP_CROSS1: begin
                mul_a = 33'(fwd_reg[ca]);
                mul_b = 31'(up_reg[cb]);
            end
            OP_CROSS2: begin
                mul_a = 33'(fwd_reg[cb]);
                mul_b = 31'(up_reg[ca]);
            end
            OP_SCALE: begin
                mul_a = {17'd0, dt_reg};
                mul_b = {15'd0, speed_reg};
            end
            OP_DELTA: begin
                mul_a = {1'b0, scale_reg};
                mul_b = cmd.sel ? 31'(rgt_reg[cmd.col]) : 31'(fwd_reg[cmd.col]);
            end
            OP_MA: begin
                mul_a = 33'(axis_reg[cmd.row]);
                mul_b = 31'(axis_reg[cmd.col]);
            end
            OP_MB: begin
                mul_a = prod_reg[32:0];
                mul_b = 31'(omc_reg);
            end
            OP_MC: begin
                mul_a = 33'(axis_reg[kx]);
                mul_b = 31'(sin_reg);
            end
            OP_RM: begin
                mul_a = vec_reg[cmd.col];
                mul_b = 31'(mr_reg[cmd.row][cmd.col]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Magnitudes and pre-scale for normalization
    always_comb begin
        mmax = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = vec_reg[i][32] ? 33'(-vec_reg[i]) : 33'(vec_reg[i]);
            if (mag[i] > mmax) begin
                mmax = mag[i];
            end
        end
        priority if (mmax[32]) begin
            nsh = 2'd3;
        end else if (mmax[31]) begin
            nsh = 2'd2;
        end else if (mmax[30]) begin
            nsh = 2'd1;
        end else begin
            nsh = 2'd0;
        end
    end

    // Square root and division steps
    assign sq_try   = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_take  = {2'b00, sq_n_reg} >= sq_try;
    assign qs       = {1'b0, q_reg};
    assign unit_val = (len == 31'd0) ? 16'sd0 : (sgn_reg[cmd.col] ? -qs : qs);

    // Move delta rounding
    assign dsum   = mul_p + (64'sd1 <<< (DELTA_SHIFT - 1));
    assign dshift = dsum >>> DELTA_SHIFT;

    // CORDIC terms
    assign cxs = cx_reg >>> iter_reg;
    assign cys = cy_reg >>> iter_reg;
    assign at  = atan_q30(iter_reg);
    assign z0  = {{2{ang_reg[15]}}, ang_reg, 17'd0};
    assign xf  = flip_reg ? -cx_reg : cx_reg;
    assign yf  = flip_reg ? -cy_reg : cy_reg;
    assign cr  = (xf + 34'sd32768) >>> 16;
    assign sr  = (yf + 34'sd32768) >>> 16;

    // Matrix entry terms
    always_comb begin
        if (cmd.row == cmd.col) begin
            mterm = 52'(cos_reg) <<< 28;
        end else if (cmd.col == nxt3(cmd.row)) begin
            mterm = -(52'(mul_p) <<< 14);
        end else begin
            mterm = 52'(mul_p) <<< 14;
        end
    end
    assign mrnd = (m_reg + 52'sd2097152) >>> 22;

    // Rotated center row
    assign rw_sum   = 66'(acc_reg) + (66'(eye_reg[cmd.row]) <<< 20) + 66'sd524288;
    assign rw_val   = 46'(rw_sum >>> 20);
    assign rw_clamp = clamp46(rw_val);

    // Pose shift for one move flag
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (cmd.col)
                SHF_LEFT:  sh_d[i] = -dr_reg[i];
                SHF_RIGHT: sh_d[i] = dr_reg[i];
                SHF_FWD:   sh_d[i] = df_reg[i];
                SHF_BACK:  sh_d[i] = -df_reg[i];
                default:   sh_d[i] = df_reg[i];
            endcase
            eye_clamp[i]  = clamp46(46'(eye_reg[i]) + 46'(sh_d[i]));
            look_clamp[i] = clamp46(46'(look_reg[i]) + 46'(sh_d[i]));
            sh_sat[i]     = eye_clamp[i][32] | look_clamp[i][32];
        end
    end

    // Pose, configuration, flags and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg[0]     <= 16'sd0;
            up_reg[1]     <= 16'sd16384;
            up_reg[2]     <= 16'sd0;
            speed_reg     <= 16'd2560;
            eye_reg[0]    <= EYE_RST_X;
            eye_reg[1]    <= EYE_RST_Y;
            eye_reg[2]    <= EYE_RST_Z;
            look_reg[0]   <= 32'sd0;
            look_reg[1]   <= 32'sd0;
            look_reg[2]   <= 32'sd0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            iter_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_UP_X:  up_reg[0] <= cfg_wdata;
                    CFG_UP_Y:  up_reg[1] <= cfg_wdata;
                    CFG_UP_Z:  up_reg[2] <= cfg_wdata;
                    CFG_SPEED: speed_reg <= cfg_wdata;
                    default:   speed_reg <= speed_reg;
                endcase
            end
            // Load a new word or drop the one taken
            if (cmd.op == OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD: begin
                    sat_reg <= 1'b0;
                end
                OP_SQRT_INIT, OP_DIV_INIT, OP_CORDIC_INIT: begin
                    iter_reg <= '0;
                end
                OP_SQRT, OP_DIV, OP_CORDIC: begin
                    iter_reg <= iter_reg + 1'b1;
                end
                OP_SHIFT: begin
                    for (int i = 0; i < 3; i++) begin
                        eye_reg[i]  <= eye_clamp[i][31:0];
                        look_reg[i] <= look_clamp[i][31:0];
                    end
                    if (|sh_sat) begin
                        sat_reg <= 1'b1;
                    end
                end
                OP_RW: begin
                    look_reg[cmd.row] <= rw_clamp[31:0];
                    if (rw_clamp[32]) begin
                        sat_reg <= 1'b1;
                    end
                end
                default: begin
                    sat_reg <= sat_reg;
                end
            endcase
        end
    end

    // Working datapath
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                flags_reg <= s_tdata[3:0];
                dt_reg    <= s_tdata[19:4];
                ang_reg   <= s_tdata[35:20];
                cmdin_reg <= s_tuser;
            end
            OP_VIEW: begin
                for (int i = 0; i < 3; i++) begin
                    vec_reg[i] <= 33'(look_reg[i]) - 33'(eye_reg[i]);
                end
            end
            OP_NSCALE: begin
                for (int i = 0; i < 3; i++) begin
                    amag_reg[i] <= 30'(mag[i] >> nsh);
                    sgn_reg[i]  <= vec_reg[i][32];
                end
                sum_reg <= '0;
            end
            OP_SQ: begin
                prod_reg <= mul_p;
                if (cmd.col != 2'd0) begin
                    sum_reg <= sum_reg + prod_reg[61:0];
                end
            end
            OP_SQEND: begin
                sum_reg <= sum_reg + prod_reg[61:0];
            end
            OP_SQRT_INIT: begin
                sq_n_reg   <= sum_reg;
                sq_res_reg <= '0;
                sq_bit_reg <= {1'b1, 62'd0};
            end
            OP_SQRT: begin
                if (sq_take) begin
                    sq_n_reg   <= sq_n_reg - sq_try[61:0];
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            OP_DIV_INIT: begin
                rem_reg <= {amag_reg[cmd.col], 14'd0};
                dsr_reg <= {len, 14'd0};
                q_reg   <= '0;
            end
            OP_DIV: begin
                if ({1'b0, rem_reg} >= dsr_reg) begin
                    rem_reg <= rem_reg - dsr_reg[43:0];
                    q_reg   <= {q_reg[13:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[13:0], 1'b0};
                end
                dsr_reg <= dsr_reg >> 1;
            end
            OP_DIV_WR: begin
                if (cmd.sel) begin
                    rgt_reg[cmd.col] <= unit_val;
                end else begin
                    fwd_reg[cmd.col] <= unit_val;
                end
            end
            OP_CROSS1: begin
                prod_reg <= mul_p;
            end
            OP_CROSS2: begin
                vec_reg[cmd.col] <= prod_reg[32:0] - mul_p[32:0];
            end
            OP_SCALE: begin
                scale_reg <= mul_p[31:0];
            end
            OP_DELTA: begin
                if (cmd.sel) begin
                    dr_reg[cmd.col] <= dshift[31:0];
                end else begin
                    df_reg[cmd.col] <= dshift[31:0];
                end
            end
            OP_AXIS: begin
                for (int i = 0; i < 3; i++) begin
                    axis_reg[i] <= (cmdin_reg == CMD_PITCH) ? rgt_reg[i] : up_reg[i];
                end
            end
            OP_CORDIC_INIT: begin
                // Fold the angle into +-pi/2 and remember to negate
                priority if (z0 > HALF_PI_Q30) begin
                    cz_reg   <= z0 - PI_Q30;
                    flip_reg <= 1'b1;
                end else if (z0 < -HALF_PI_Q30) begin
                    cz_reg   <= z0 + PI_Q30;
                    flip_reg <= 1'b1;
                end else begin
                    cz_reg   <= z0;
                    flip_reg <= 1'b0;
                end
                cx_reg <= CORDIC_GAIN;
                cy_reg <= '0;
            end
            OP_CORDIC: begin
                if (!cz_reg[34]) begin
                    cx_reg <= cx_reg - cys;
                    cy_reg <= cy_reg + cxs;
                    cz_reg <= cz_reg - at;
                end else begin
                    cx_reg <= cx_reg + cys;
                    cy_reg <= cy_reg - cxs;
                    cz_reg <= cz_reg + at;
                end
            end
            OP_CS: begin
                cos_reg <= cr[17:0];
                sin_reg <= sr[17:0];
                omc_reg <= ONE_Q14 - 19'(cr);
            end
            OP_MA, OP_MB: begin
                prod_reg <= mul_p;
            end
            OP_MC: begin
                m_reg <= prod_reg[51:0] + mterm;
            end
            OP_MD: begin
                mr_reg[cmd.row][cmd.col] <= mrnd[27:0];
            end
            OP_RM: begin
                prod_reg <= mul_p;
                if (cmd.col == 2'd0) begin
                    acc_reg <= '0;
                end else begin
                    acc_reg <= acc_reg + prod_reg;
                end
            end
            OP_RE: begin
                acc_reg <= acc_reg + prod_reg;
            end
            OP_OUT: begin
                out_data_reg <= {7'd0, sat_reg,
                                 look_reg[2], look_reg[1], look_reg[0],
                                 eye_reg[2], eye_reg[1], eye_reg[0]};
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign stat.iter_last = (cmd.op == OP_SQRT   && iter_reg == ITER_W'(SQRT_STEPS - 1)) ||
                            (cmd.op == OP_DIV    && iter_reg == ITER_W'(DIV_STEPS - 1)) ||
                            (cmd.op == OP_CORDIC && iter_reg == ITER_W'(CORDIC_ITERS - 1));
    assign stat.cmd       = cmdin_reg;
    assign stat.flags     = flags_reg;
    assign stat.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
